// ===== hdl/kfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Keybus frame receiver package
// Shared constants, register indexes and the control types that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package kfr_pkg;

   localparam int GAP_W      = 16;
   localparam int BYTE_W     = 8;
   localparam int INDEX_W    = 4;
   localparam int COUNT_W    = 8;
   localparam int CFG_IDX_W  = 2;
   localparam int CFG_DATA_W = 16;

   localparam logic [CFG_IDX_W-1:0] CFG_KEYPAD_GAP = 2'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_PANEL_GAP  = 2'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_MIN_BITS   = 2'd2;

   localparam logic [GAP_W-1:0]  KEYPAD_GAP_RESET = 16'd14800;
   localparam logic [GAP_W-1:0]  PANEL_GAP_RESET  = 16'd15200;
   localparam logic [BYTE_W-1:0] MIN_BITS_RESET   = 8'd8;

   localparam int MAX_EMIT      = 16;
   localparam int SUM_MIN_BITS  = 17;
   localparam int KEY_TEST_BYTES = 4;

   localparam logic [BYTE_W-1:0] BYTE_ALL_ONES = 8'hFF;

   typedef struct packed {
      logic accept;
      logic seq_clear;
      logic scan_init;
      logic rd_en;
      logic rd_emit;
      logic scan_acc;
      logic flags_load;
      logic out_load;
      logic finish;
   } kfr_cmd_type;

   typedef struct packed {
      logic complete;
      logic scan_last;
      logic seq_last;
   } kfr_status_type;

   typedef struct packed {
      logic               channel;
      logic [INDEX_W-1:0] byte_index;
      logic [BYTE_W-1:0]  byte_value;
      logic [COUNT_W-1:0] bit_count;
      logic               new_word;
      logic               checksum_ok;
      logic               last;
   } kfr_word_type;

endpackage

// ===== hdl/kfr_channels.sv =====
// ----------------------------------------------------------------------------
// Keybus frame receiver channels
// Valid/ready channels for the edge words and the frame byte words.
// ----------------------------------------------------------------------------
interface kfr_req_if import kfr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             clock_level;
   logic             data_bit;
   logic [GAP_W-1:0] gap_us;

   modport source (output valid, output clock_level, output data_bit, output gap_us,
                   input ready);
   modport sink   (input valid, input clock_level, input data_bit, input gap_us,
                   output ready);
endinterface

interface kfr_rsp_if import kfr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               channel;
   logic [INDEX_W-1:0] byte_index;
   logic [BYTE_W-1:0]  byte_value;
   logic [COUNT_W-1:0] bit_count;
   logic               new_word;
   logic               checksum_ok;
   logic               last;

   modport source (output valid, output channel, output byte_index, output byte_value,
                   output bit_count, output new_word, output checksum_ok, output last,
                   input ready);
   modport sink   (input valid, input channel, input byte_index, input byte_value,
                   input bit_count, input new_word, input checksum_ok, input last,
                   output ready);
endinterface

// ===== hdl/keybus_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Keybus frame receiver
// Assembles panel and keypad frames from keybus clock edges and emits both
// frames byte by byte when a panel word completes.
// ----------------------------------------------------------------------------
// An edge that completes no panel word leaves the receiver ready; edges follow back to back.
// A completing edge scans all FRAME_BYTES frame entries; its byte words follow
// the scan and the flags step, one byte word a cycle while the sink is ready.
// After a completing edge, edges are taken again once all its byte words have
// passed the read stage; sink stalls hold this off.
// Reset clears all frames, counters and the previous panel word, and loads defaults.
module keybus_frame_receiver import kfr_pkg::*; #(
   parameter int FRAME_BYTES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   kfr_req_if.sink               req_bus,
   kfr_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_wdata
);
   kfr_cmd_type    cmd;
   kfr_status_type status;
   kfr_word_type   rsp_word;

   kfr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kfr_datapath #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .clock_level (req_bus.clock_level),
      .data_bit    (req_bus.data_bit),
      .gap_us      (req_bus.gap_us),
      .cmd         (cmd),
      .status      (status),
      .rsp_word    (rsp_word)
   );

   assign rsp_bus.channel     = rsp_word.channel;
   assign rsp_bus.byte_index  = rsp_word.byte_index;
   assign rsp_bus.byte_value  = rsp_word.byte_value;
   assign rsp_bus.bit_count   = rsp_word.bit_count;
   assign rsp_bus.new_word    = rsp_word.new_word;
   assign rsp_bus.checksum_ok = rsp_word.checksum_ok;
   assign rsp_bus.last        = rsp_word.last;
endmodule

// ===== hdl/kfr_ram.sv =====
// ----------------------------------------------------------------------------
// Keybus frame receiver RAM
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module kfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/kfr_datapath.sv =====
// ----------------------------------------------------------------------------
// Keybus frame receiver datapath
// Frame assembly into banked RAMs, the scan that compares and sums the panel
// frame, the byte read sequence and the output word register.
// ----------------------------------------------------------------------------
module kfr_datapath import kfr_pkg::*; #(
   parameter int FRAME_BYTES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_wdata,
   input  logic                  clock_level,
   input  logic                  data_bit,
   input  logic [GAP_W-1:0]      gap_us,
   input  kfr_cmd_type           cmd,
   output kfr_status_type        status,
   output kfr_word_type          rsp_word
);
   localparam int POS_W    = $clog2(FRAME_BYTES);
   localparam int CNT_W    = $clog2(FRAME_BYTES + 1);
   localparam int BITS_W   = $clog2(8 * FRAME_BYTES + 1);
   localparam int CMP_W    = (BITS_W > BYTE_W) ? BITS_W : BYTE_W;
   localparam int EMIT_CAP = (FRAME_BYTES < MAX_EMIT) ? FRAME_BYTES : MAX_EMIT;

   function automatic logic [POS_W-1:0] panel_last(input logic [BITS_W-1:0] bits);
      int n;
      if (bits <= BITS_W'(8)) begin
         n = 1;
      end else begin
         n = 2 + ((int'(bits) - 2) >> 3);
      end
      if (n > EMIT_CAP) begin
         n = EMIT_CAP;
      end
      return POS_W'(n - 1);
   endfunction

   function automatic logic [POS_W-1:0] keypad_last(input logic [BITS_W-1:0] bits);
      int n;
      n = (int'(bits) + 7) >> 3;
      if (n == 0) begin
         n = 1;
      end
      if (n > EMIT_CAP) begin
         n = EMIT_CAP;
      end
      return POS_W'(n - 1);
   endfunction

   function automatic logic [COUNT_W-1:0] sat_count(input logic [BITS_W-1:0] bits);
      if (CMP_W'(bits) > CMP_W'(BYTE_ALL_ONES)) begin
         return BYTE_ALL_ONES;
      end
      return COUNT_W'(bits);
   endfunction

   // Configuration registers.
   logic [GAP_W-1:0]  kgap_ff;
   logic [GAP_W-1:0]  pgap_ff;
   logic [BYTE_W-1:0] pmin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kgap_ff <= KEYPAD_GAP_RESET;
         pgap_ff <= PANEL_GAP_RESET;
         pmin_ff <= MIN_BITS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_KEYPAD_GAP: kgap_ff <= csr_wdata;
            CFG_PANEL_GAP:  pgap_ff <= csr_wdata;
            CFG_MIN_BITS:   pmin_ff <= csr_wdata[BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Panel and keypad assembly state. Each side has two RAM banks; the bank
   // that is not being built holds the previous panel word or the saved
   // keypad word.
   logic                   pbank_ff, pbank_in;
   logic [CNT_W-1:0]       ppos_ff, ppos_in;
   logic [2:0]             pbit_ff, pbit_in;
   logic [BITS_W-1:0]      pbits_ff, pbits_in;
   logic [BYTE_W-1:0]      pbyte_ff, pbyte_in;
   logic [FRAME_BYTES-1:0] pvalid_ff [2];
   logic [FRAME_BYTES-1:0] pvalid_in [2];
   logic [BITS_W-1:0]      wbits_ff, wbits_in;

   logic                   kbank_ff, kbank_in;
   logic [CNT_W-1:0]       kpos_ff, kpos_in;
   logic [2:0]             kbit_ff, kbit_in;
   logic [BITS_W-1:0]      kbits_ff, kbits_in;
   logic [BYTE_W-1:0]      kbyte_ff, kbyte_in;
   logic [FRAME_BYTES-1:0] kvalid_ff [2];
   logic [FRAME_BYTES-1:0] kvalid_in [2];
   logic [BITS_W-1:0]      ksbits_ff, ksbits_in;

   logic                   ksave;
   logic                   kbank_cur;
   logic [CNT_W-1:0]       kpos_cur;
   logic [2:0]             kbit_cur;
   logic [BITS_W-1:0]      kbits_cur;
   logic [BYTE_W-1:0]      kbyte_cur;
   logic [BYTE_W-1:0]      knb;
   logic                   kwr;

   logic [BYTE_W-1:0]      pnb;
   logic                   pfit;
   logic                   pwr;
   logic [BITS_W-1:0]      pbits_new;
   logic                   complete;

   logic                   pnew_ff, pnew_in;

   always_comb begin
      pfit      = clock_level && (ppos_ff < CNT_W'(FRAME_BYTES));
      pbits_new = pfit ? pbits_ff + BITS_W'(1) : pbits_ff;
      complete  = (gap_us >= pgap_ff) && (CMP_W'(pbits_new) >= CMP_W'(pmin_ff));
   end

   always_comb begin
      ksave     = gap_us > kgap_ff;
      kbank_cur = ksave ? ~kbank_ff : kbank_ff;
      kpos_cur  = ksave ? '0 : kpos_ff;
      kbit_cur  = ksave ? '0 : kbit_ff;
      kbits_cur = ksave ? '0 : kbits_ff;
      kbyte_cur = ksave ? '0 : kbyte_ff;
      knb       = {kbyte_cur[BYTE_W-2:0], data_bit};
      kwr       = cmd.accept && !clock_level && (kpos_cur < CNT_W'(FRAME_BYTES));

      pnb       = {pbyte_ff[BYTE_W-2:0], data_bit};
      pwr       = cmd.accept && pfit;
   end

   always_comb begin
      kbank_in  = kbank_ff;
      kpos_in   = kpos_ff;
      kbit_in   = kbit_ff;
      kbits_in  = kbits_ff;
      kbyte_in  = kbyte_ff;
      kvalid_in = kvalid_ff;
      ksbits_in = ksbits_ff;
      if (cmd.accept) begin
         kbank_in = kbank_cur;
         kpos_in  = kpos_cur;
         kbit_in  = kbit_cur;
         kbits_in = kbits_cur;
         kbyte_in = kbyte_cur;
         if (ksave) begin
            ksbits_in            = kbits_ff;
            kvalid_in[kbank_cur] = '0;
         end
         if (kwr) begin
            kvalid_in[kbank_cur][kpos_cur[POS_W-1:0]] = 1'b1;
            kbits_in = kbits_cur + BITS_W'(1);
            if (kbit_cur < 3'd7) begin
               kbit_in  = kbit_cur + 3'd1;
               kbyte_in = knb;
            end else begin
               kbit_in  = '0;
               kbyte_in = '0;
               kpos_in  = kpos_cur + CNT_W'(1);
            end
         end
      end
   end

   always_comb begin
      pbank_in  = pbank_ff;
      ppos_in   = ppos_ff;
      pbit_in   = pbit_ff;
      pbits_in  = pbits_ff;
      pbyte_in  = pbyte_ff;
      pvalid_in = pvalid_ff;
      wbits_in  = wbits_ff;
      if (pwr) begin
         pvalid_in[pbank_ff][ppos_ff[POS_W-1:0]] = 1'b1;
         pbits_in = pbits_new;
         if (ppos_ff == '0 && pbit_ff == 3'd7) begin
            // The lone ninth bit of the panel frame gets a byte of its own.
            ppos_in  = CNT_W'(1);
            pbit_in  = 3'd7;
            pbyte_in = '0;
         end else if (pbit_ff < 3'd7) begin
            pbit_in  = pbit_ff + 3'd1;
            pbyte_in = pnb;
         end else begin
            ppos_in  = ppos_ff + CNT_W'(1);
            pbit_in  = '0;
            pbyte_in = '0;
         end
      end
      if (cmd.accept && complete) begin
         wbits_in = pbits_new;
         ppos_in  = '0;
         pbit_in  = '0;
         pbits_in = '0;
         pbyte_in = '0;
      end
      if (cmd.finish) begin
         // A new word becomes the previous word and the other bank is rebuilt; else the bank just built is rebuilt.
         pbank_in            = pnew_ff ? ~pbank_ff : pbank_ff;
         pvalid_in[pbank_in] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pbank_ff  <= 1'b0;
         ppos_ff   <= '0;
         pbit_ff   <= '0;
         pbits_ff  <= '0;
         pbyte_ff  <= '0;
         pvalid_ff <= '{default: '0};
         kbank_ff  <= 1'b0;
         kpos_ff   <= '0;
         kbit_ff   <= '0;
         kbits_ff  <= '0;
         kbyte_ff  <= '0;
         kvalid_ff <= '{default: '0};
         ksbits_ff <= '0;
      end else begin
         pbank_ff  <= pbank_in;
         ppos_ff   <= ppos_in;
         pbit_ff   <= pbit_in;
         pbits_ff  <= pbits_in;
         pbyte_ff  <= pbyte_in;
         pvalid_ff <= pvalid_in;
         kbank_ff  <= kbank_in;
         kpos_ff   <= kpos_in;
         kbit_ff   <= kbit_in;
         kbits_ff  <= kbits_in;
         kbyte_ff  <= kbyte_in;
         kvalid_ff <= kvalid_in;
         ksbits_ff <= ksbits_in;
      end
   end

   always_ff @(posedge clock) begin
      wbits_ff <= wbits_in;
   end

   // Read sequence, shared by all four banks.
   logic [POS_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_ch_ff, rd_ch_in;
   logic [POS_W-1:0] np_last_ff, np_last_in;
   logic [POS_W-1:0] nk_last_ff, nk_last_in;

   logic [BYTE_W-1:0] pram_q [2];
   logic [BYTE_W-1:0] kram_q [2];

   for (genvar b = 0; b < 2; b++) begin : g_bank
      kfr_ram #(
         .WIDTH (BYTE_W),
         .DEPTH (FRAME_BYTES)
      ) u_panel_ram (
         .clock   (clock),
         .wr_en   (pwr && (pbank_ff == 1'(b))),
         .wr_addr (ppos_ff[POS_W-1:0]),
         .wr_data (pnb),
         .rd_en   (cmd.rd_en),
         .rd_addr (rd_idx_ff),
         .rd_data (pram_q[b])
      );

      kfr_ram #(
         .WIDTH (BYTE_W),
         .DEPTH (FRAME_BYTES)
      ) u_keypad_ram (
         .clock   (clock),
         .wr_en   (kwr && (kbank_cur == 1'(b))),
         .wr_addr (kpos_cur[POS_W-1:0]),
         .wr_data (knb),
         .rd_en   (cmd.rd_en),
         .rd_addr (rd_idx_ff),
         .rd_data (kram_q[b])
      );
   end

   always_comb begin
      rd_idx_in = rd_idx_ff;
      rd_ch_in  = rd_ch_ff;
      if (cmd.seq_clear) begin
         rd_idx_in = '0;
         rd_ch_in  = 1'b0;
      end else if (cmd.rd_en) begin
         if (cmd.rd_emit && !rd_ch_ff && rd_idx_ff == np_last_ff) begin
            rd_idx_in = '0;
            rd_ch_in  = 1'b1;
         end else begin
            rd_idx_in = rd_idx_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         rd_ch_ff  <= 1'b0;
      end else begin
         rd_idx_ff <= rd_idx_in;
         rd_ch_ff  <= rd_ch_in;
      end
   end

   // Read stage: valid bits and position travel with the RAM data.
   logic [1:0]       pv_rd_ff;
   logic [1:0]       kv_rd_ff;
   logic             b_ch_ff;
   logic [POS_W-1:0] b_idx_ff;
   logic             b_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         pv_rd_ff  <= {pvalid_ff[1][rd_idx_ff], pvalid_ff[0][rd_idx_ff]};
         kv_rd_ff  <= {kvalid_ff[1][rd_idx_ff], kvalid_ff[0][rd_idx_ff]};
         b_ch_ff   <= rd_ch_ff;
         b_idx_ff  <= rd_idx_ff;
         b_last_ff <= status.seq_last;
      end
   end

   logic [BYTE_W-1:0] pdat;
   logic [BYTE_W-1:0] prv;
   logic [BYTE_W-1:0] kdat;

   always_comb begin
      pdat = pv_rd_ff[pbank_ff]  ? pram_q[pbank_ff]  : '0;
      prv  = pv_rd_ff[~pbank_ff] ? pram_q[~pbank_ff] : '0;
      kdat = kv_rd_ff[~kbank_ff] ? kram_q[~kbank_ff] : '0;
   end

   // Scan accumulators.
   logic              diff_ff, diff_in;
   logic              w0nz_ff, w0nz_in;
   logic              kb0nz_ff, kb0nz_in;
   logic              kff_ff, kff_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] chk_ff, chk_in;
   logic [BITS_W-1:0] g_w;
   logic [BITS_W-1:0] bi;
   logic              ok_ff, ok_in;
   logic              knew_ff, knew_in;

   always_comb begin
      g_w      = (wbits_ff - BITS_W'(9)) >> 3;
      bi       = BITS_W'(b_idx_ff);
      diff_in  = diff_ff;
      w0nz_in  = w0nz_ff;
      kb0nz_in = kb0nz_ff;
      kff_in   = kff_ff;
      sum_in   = sum_ff;
      chk_in   = chk_ff;
      if (cmd.scan_init) begin
         diff_in  = 1'b0;
         w0nz_in  = 1'b0;
         kb0nz_in = 1'b0;
         kff_in   = 1'b1;
         sum_in   = '0;
         chk_in   = '0;
      end else if (cmd.scan_acc) begin
         if (pdat != prv) begin
            diff_in = 1'b1;
         end
         if (bi == '0) begin
            w0nz_in  = pdat != '0;
            kb0nz_in = kdat != '0;
         end
         if (bi == '0 || (bi >= BITS_W'(2) && bi <= g_w)) begin
            sum_in = sum_ff + pdat;
         end
         if (bi == g_w + BITS_W'(1)) begin
            chk_in = pdat;
         end
         if (bi < BITS_W'(KEY_TEST_BYTES) && kdat != BYTE_ALL_ONES) begin
            kff_in = 1'b0;
         end
      end
   end

   always_comb begin
      pnew_in    = pnew_ff;
      knew_in    = knew_ff;
      ok_in      = ok_ff;
      np_last_in = np_last_ff;
      nk_last_in = nk_last_ff;
      if (cmd.flags_load) begin
         pnew_in    = w0nz_ff && diff_ff;
         knew_in    = kb0nz_ff && !kff_ff;
         ok_in      = (wbits_ff >= BITS_W'(SUM_MIN_BITS))
                      && (({1'b0, g_w} + (BITS_W+1)'(1)) < (BITS_W+1)'(FRAME_BYTES))
                      && (sum_ff == chk_ff);
         np_last_in = panel_last(wbits_ff);
         nk_last_in = keypad_last(ksbits_ff);
      end
   end

   always_ff @(posedge clock) begin
      diff_ff    <= diff_in;
      w0nz_ff    <= w0nz_in;
      kb0nz_ff   <= kb0nz_in;
      kff_ff     <= kff_in;
      sum_ff     <= sum_in;
      chk_ff     <= chk_in;
      pnew_ff    <= pnew_in;
      knew_ff    <= knew_in;
      ok_ff      <= ok_in;
      np_last_ff <= np_last_in;
      nk_last_ff <= nk_last_in;
   end

   // Output word register.
   kfr_word_type out_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.channel     <= b_ch_ff;
         out_ff.byte_index  <= INDEX_W'(b_idx_ff);
         out_ff.byte_value  <= b_ch_ff ? kdat : pdat;
         out_ff.bit_count   <= b_ch_ff ? sat_count(ksbits_ff) : sat_count(wbits_ff);
         out_ff.new_word    <= b_ch_ff ? knew_ff : pnew_ff;
         out_ff.checksum_ok <= !b_ch_ff && ok_ff;
         out_ff.last        <= b_last_ff;
      end
   end

   assign rsp_word = out_ff;

   assign status.complete  = complete;
   assign status.scan_last = rd_idx_ff == POS_W'(FRAME_BYTES - 1);
   assign status.seq_last  = rd_ch_ff && (rd_idx_ff == nk_last_ff);
endmodule

// ===== hdl/kfr_controller.sv =====
// ----------------------------------------------------------------------------
// Keybus frame receiver controller
// Sequences edge acceptance, the frame scan and the byte emission, and owns
// the valid bits of the read stage and the output word register.
// ----------------------------------------------------------------------------
module kfr_controller import kfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  kfr_status_type status,
   output kfr_cmd_type    cmd
);
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_SCANEND = 3'd2;
   localparam logic [2:0] S_FLAGS   = 3'd3;
   localparam logic [2:0] S_EMIT    = 3'd4;
   localparam logic [2:0] S_DRAIN   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       b_vld_ff, b_vld_in;
   logic       out_vld_ff, out_vld_in;
   logic       accept;
   logic       out_free;

   always_comb begin
      req_ready  = state_ff == S_IDLE;
      accept     = req_valid && req_ready;
      out_free   = !out_vld_ff || rsp_ready;
      cmd        = '0;
      state_in   = state_ff;
      b_vld_in   = b_vld_ff;
      out_vld_in = out_vld_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = accept;
            if (accept && status.complete) begin
               cmd.seq_clear = 1'b1;
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.rd_en    = 1'b1;
            cmd.scan_acc = b_vld_ff;
            b_vld_in     = 1'b1;
            if (status.scan_last) begin
               state_in = S_SCANEND;
            end
         end
         S_SCANEND: begin
            cmd.scan_acc = b_vld_ff;
            b_vld_in     = 1'b0;
            state_in     = S_FLAGS;
         end
         S_FLAGS: begin
            cmd.flags_load = 1'b1;
            cmd.seq_clear  = 1'b1;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            cmd.out_load = b_vld_ff && out_free;
            cmd.rd_en    = !b_vld_ff || out_free;
            cmd.rd_emit  = 1'b1;
            b_vld_in     = 1'b1;
            if (cmd.out_load) begin
               out_vld_in = 1'b1;
            end
            if (cmd.rd_en && status.seq_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cmd.out_load = b_vld_ff && out_free;
            b_vld_in     = b_vld_ff && !out_free;
            if (cmd.out_load) begin
               out_vld_in = 1'b1;
            end
            if (!b_vld_ff) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            b_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         b_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         b_vld_ff   <= b_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_valid = out_vld_ff;

   a_idle_stage_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !b_vld_ff)
      else $error("read stage holds a word while accepting edges");

   a_complete_scans: assert property (@(posedge clock) disable iff (reset)
      accept && status.complete |=> state_ff == S_SCAN)
      else $error("completed panel word did not start a scan");

   a_out_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(cmd.out_load))
      else $error("output word became valid without a load");
endmodule

// ===== tb/sv/tb_kfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keybus frame receiver scoreboard
// Tracks the panel and keypad frame builders the way the receiver should,
// works out which frame bytes each accepted edge word releases, and checks
// the words leaving the receiver against them in arrival order.
// ----------------------------------------------------------------------------
package tb_kfr_pkg;
   import kfr_pkg::*;

   localparam int FRAME_BYTES = 16;

   class kfr_frame_scoreboard;
      logic [GAP_W-1:0]  keypad_gap;
      logic [GAP_W-1:0]  panel_gap;
      logic [BYTE_W-1:0] min_bits;

      logic [BYTE_W-1:0] panel_store [FRAME_BYTES];
      int                panel_total;
      int                panel_byte;
      int                panel_bit;
      logic [BYTE_W-1:0] keypad_store [FRAME_BYTES];
      int                keypad_total;
      int                keypad_byte;
      int                keypad_bit;
      logic [BYTE_W-1:0] keypad_kept [FRAME_BYTES];
      int                keypad_kept_total;
      logic [BYTE_W-1:0] prior_panel [FRAME_BYTES];

      kfr_word_type      frame_bytes_due [$];
      int                errors;
      int                bytes_checked;
      int                words_completed;

      function new();
         keypad_gap = KEYPAD_GAP_RESET;
         panel_gap  = PANEL_GAP_RESET;
         min_bits   = MIN_BITS_RESET;
         foreach (panel_store[j]) begin
            panel_store[j]  = '0;
            keypad_store[j] = '0;
            keypad_kept[j]  = '0;
            prior_panel[j]  = '0;
         end
         panel_total       = 0;
         panel_byte        = 0;
         panel_bit         = 0;
         keypad_total      = 0;
         keypad_byte       = 0;
         keypad_bit        = 0;
         keypad_kept_total = 0;
         errors            = 0;
         bytes_checked     = 0;
         words_completed   = 0;
      endfunction

      function void write_reg(logic [CFG_IDX_W-1:0] reg_index, logic [CFG_DATA_W-1:0] value);
         case (reg_index)
            CFG_KEYPAD_GAP: keypad_gap = value;
            CFG_PANEL_GAP:  panel_gap  = value;
            CFG_MIN_BITS:   min_bits   = value[BYTE_W-1:0];
            default: ;
         endcase
      endfunction

      function void predict_edge(logic level, logic data_bit, logic [GAP_W-1:0] gap);
         logic [BYTE_W-1:0] word [FRAME_BYTES];
         logic [BYTE_W-1:0] sum8;
         int                wbits;
         int                np;
         int                nk;
         int                g;
         int                i;
         bit                fresh_panel;
         bit                fresh_keypad;
         bit                all_ones;
         bit                sum_ok;
         kfr_word_type      w;

         if (gap > keypad_gap) begin
            keypad_kept       = keypad_store;
            keypad_kept_total = keypad_total;
            foreach (keypad_store[j]) keypad_store[j] = '0;
            keypad_total = 0;
            keypad_byte  = 0;
            keypad_bit   = 0;
         end

         if (level) begin
            if (panel_byte < FRAME_BYTES) begin
               panel_store[panel_byte] = {panel_store[panel_byte][BYTE_W-2:0], data_bit};
               panel_total++;
               // The second panel group holds a single bit.
               if (panel_byte == 0 && panel_bit == 7) begin
                  panel_byte = 1;
                  panel_bit  = 6;
               end
               if (panel_bit < 7) begin
                  panel_bit++;
               end else begin
                  panel_byte++;
                  panel_bit = 0;
               end
            end
         end else begin
            if (keypad_byte < FRAME_BYTES) begin
               keypad_store[keypad_byte] = {keypad_store[keypad_byte][BYTE_W-2:0], data_bit};
               keypad_total++;
               if (keypad_bit < 7) begin
                  keypad_bit++;
               end else begin
                  keypad_byte++;
                  keypad_bit = 0;
               end
            end
         end

         if (gap < panel_gap || panel_total < min_bits) return;

         words_completed++;
         word  = panel_store;
         wbits = panel_total;
         foreach (panel_store[j]) panel_store[j] = '0;
         panel_total = 0;
         panel_byte  = 0;
         panel_bit   = 0;

         fresh_panel = 1'b0;
         if (word[0] != 0) begin
            for (i = 0; i < FRAME_BYTES; i++)
               if (word[i] != prior_panel[i]) fresh_panel = 1'b1;
         end
         if (fresh_panel) prior_panel = word;

         sum_ok = 1'b0;
         if (wbits >= SUM_MIN_BITS) begin
            g = (wbits - 9) / 8;
            if (g + 1 < FRAME_BYTES) begin
               sum8 = word[0];
               for (i = 2; i <= g; i++) sum8 += word[i];
               sum_ok = (sum8 == word[g + 1]);
            end
         end

         all_ones = 1'b1;
         for (i = 0; i < KEY_TEST_BYTES; i++)
            if (keypad_kept[i] != BYTE_ALL_ONES) all_ones = 1'b0;
         fresh_keypad = (keypad_kept[0] != 0) && !all_ones;

         np = (wbits <= 8) ? 1 : 2 + (wbits - 2) / 8;
         if (np > FRAME_BYTES) np = FRAME_BYTES;
         if (np > MAX_EMIT) np = MAX_EMIT;
         nk = (keypad_kept_total + 7) / 8;
         if (nk == 0) nk = 1;
         if (nk > FRAME_BYTES) nk = FRAME_BYTES;
         if (nk > MAX_EMIT) nk = MAX_EMIT;

         for (i = 0; i < np; i++) begin
            w.channel     = 1'b0;
            w.byte_index  = i[INDEX_W-1:0];
            w.byte_value  = word[i];
            w.bit_count   = (wbits > 255) ? 8'hFF : wbits[COUNT_W-1:0];
            w.new_word    = fresh_panel;
            w.checksum_ok = sum_ok;
            w.last        = 1'b0;
            frame_bytes_due.push_back(w);
         end
         for (i = 0; i < nk; i++) begin
            w.channel     = 1'b1;
            w.byte_index  = i[INDEX_W-1:0];
            w.byte_value  = keypad_kept[i];
            w.bit_count   = (keypad_kept_total > 255) ? 8'hFF
                                                      : keypad_kept_total[COUNT_W-1:0];
            w.new_word    = fresh_keypad;
            w.checksum_ok = 1'b0;
            w.last        = (i == nk - 1);
            frame_bytes_due.push_back(w);
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 200) $display("MISMATCH %s", msg);
      endtask

      task compare_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
         if (got !== want)
            report($sformatf("byte %0d: %s is %0d, expected %0d", bytes_checked, name, got,
                             want));
      endtask

      task check_byte(kfr_word_type got);
         kfr_word_type want;
         if (frame_bytes_due.size() == 0) begin
            report($sformatf("frame byte with nothing pending: channel %0d index %0d value %02h",
                             got.channel, got.byte_index, got.byte_value));
            return;
         end
         want = frame_bytes_due.pop_front();
         bytes_checked++;
         compare_field("channel", got.channel, want.channel);
         compare_field("byte_index", got.byte_index, want.byte_index);
         compare_field("byte_value", got.byte_value, want.byte_value);
         compare_field("bit_count", got.bit_count, want.bit_count);
         compare_field("new_word", got.new_word, want.new_word);
         compare_field("checksum_ok", got.checksum_ok, want.checksum_ok);
         compare_field("last", got.last, want.last);
      endtask
   endclass

endpackage

// ===== tb/sv/tb_keybus_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keybus frame receiver testbench
// Feeds keybus edge words built as panel and keypad frames with random content,
// crafted checksums, repeated words and stray edges, under several threshold
// settings, and checks every frame byte the receiver emits against the
// scoreboard while both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_keybus_frame_receiver;
   import kfr_pkg::*;
   import tb_kfr_pkg::*;

   localparam int DRAIN_CYCLES = FRAME_BYTES + 2 * MAX_EMIT + 10;
   localparam int HOLD_CYCLES  = 400;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CFG_IDX_W-1:0]  csr_index;
   logic [CFG_DATA_W-1:0] csr_wdata;

   kfr_req_if req_bus ();
   kfr_rsp_if rsp_bus ();

   kfr_frame_scoreboard frames = new();

   bit calm;
   bit hold_request;
   int edges_sent;
   int settings_used;
   bit last_panel [$];

   keybus_frame_receiver #(.FRAME_BYTES(FRAME_BYTES)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin : rx_pace
      int hold_left;
      int stall_left;
      bit hold_taken;
      hold_left    = 0;
      stall_left   = 0;
      hold_taken   = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready = 1'b0;
         end else if (calm || $urandom_range(0, 99) < 70) begin
            rsp_bus.ready = 1'b1;
         end else begin
            rsp_bus.ready = 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                     : $urandom_range(0, 2);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         frames.check_byte({rsp_bus.channel, rsp_bus.byte_index, rsp_bus.byte_value,
                            rsp_bus.bit_count, rsp_bus.new_word, rsp_bus.checksum_ok,
                            rsp_bus.last});
   end

   function automatic int idle_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [GAP_W-1:0] frame_gap();
      int lim;
      lim = int'(frames.keypad_gap);
      if (frames.panel_gap == 0) lim = 0;
      else if (int'(frames.panel_gap) - 1 < lim) lim = int'(frames.panel_gap) - 1;
      return GAP_W'($urandom_range(0, lim));
   endfunction

   function automatic logic [GAP_W-1:0] long_gap();
      int lo;
      lo = int'(frames.panel_gap);
      if ($urandom_range(0, 3) != 0 && frames.keypad_gap != 16'hFFFF &&
          int'(frames.keypad_gap) + 1 > lo)
         lo = int'(frames.keypad_gap) + 1;
      case ($urandom_range(0, 2))
         0:       return GAP_W'(lo);
         1:       return 16'hFFFF;
         default: return GAP_W'($urandom_range(lo, 65535));
      endcase
   endfunction

   function automatic logic [GAP_W-1:0] noise_gap();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return frames.keypad_gap;
         3:       return frames.panel_gap;
         4:       return frames.panel_gap - 1'b1;
         default: return GAP_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic void push_bits(ref bit q[$], input logic [7:0] value, input int count);
      int j;
      for (j = count - 1; j >= 0; j--) q.push_back(value[j]);
   endfunction

   task automatic send_edge(input logic level, input logic data_bit, input logic [GAP_W-1:0] gap);
      int pause;
      pause = idle_len();
      @(negedge clock);
      if (pause > 0) begin
         req_bus.valid = 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.clock_level = level;
      req_bus.data_bit    = data_bit;
      req_bus.gap_us      = gap;
      do @(posedge clock); while (!req_bus.ready);
      frames.predict_edge(level, data_bit, gap);
      edges_sent++;
   endtask

   task automatic send_noise();
      send_edge(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), noise_gap());
   endtask

   task automatic send_frame(input bit pbits[$], input bit kbits[$],
                             input logic [GAP_W-1:0] end_gap);
      int   total;
      int   k;
      logic level;
      logic value;
      total = pbits.size() + kbits.size();
      if (total == 0) begin
         send_edge(1'b1, 1'($urandom_range(0, 1)), end_gap);
         return;
      end
      for (k = 0; k < total; k++) begin
         if (kbits.size() == 0) level = 1'b1;
         else if (pbits.size() == 0) level = 1'b0;
         else level = 1'($urandom_range(0, 1));
         value = level ? pbits.pop_front() : kbits.pop_front();
         send_edge(level, value, (k == total - 1) ? end_gap : frame_gap());
      end
   endtask

   task automatic write_csr(input logic [CFG_IDX_W-1:0] reg_index,
                            input logic [CFG_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = reg_index;
      csr_wdata = value;
      @(posedge clock);
      frames.write_reg(reg_index, value);
   endtask

   task automatic set_config(input logic [GAP_W-1:0] keypad_gap, input logic [GAP_W-1:0] panel_gap,
                             input logic [BYTE_W-1:0] min_bits);
      write_csr(CFG_KEYPAD_GAP, keypad_gap);
      write_csr(CFG_PANEL_GAP, panel_gap);
      write_csr(CFG_MIN_BITS, {8'h00, min_bits});
      @(negedge clock);
      csr_we = 1'b0;
      settings_used++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (frames.frame_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_directed();
      bit pbits[$];
      bit kbits[$];
      // An all-zero 17-bit word: the checksum matches on a zero sum.
      repeat (17) pbits.push_back(1'b0);
      kbits.push_back(1'b1);
      send_frame(pbits, kbits, 16'hFFFF);
      // A gap between the two thresholds saves the keypad frame only.
      send_edge(1'b0, 1'b1, 16'd15000);
      pbits.delete();
      kbits.delete();
      repeat (8) pbits.push_back(1'b1);
      send_frame(pbits, kbits, PANEL_GAP_RESET);
      send_edge(1'b1, 1'b0, 16'd0);
   endtask

   task automatic random_frame();
      bit               pbits[$];
      bit               kbits[$];
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] sum8;
      int               k;
      int               n;
      int               j;
      int               r;
      int               r2;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         repeat ($urandom_range(1, 5)) send_noise();
         return;
      end
      if (r < 40) begin
         k = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 13) : $urandom_range(1, 6);
         b = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom);
         sum8 = b;
         push_bits(pbits, b, 8);
         push_bits(pbits, 8'($urandom), 1);
         for (j = 2; j <= k; j++) begin
            b = 8'($urandom);
            sum8 += b;
            push_bits(pbits, b, 8);
         end
         if ($urandom_range(0, 4) == 0) sum8 ^= 8'($urandom_range(1, 255));
         push_bits(pbits, sum8, 8);
      end else if (r < 55 && last_panel.size() != 0) begin
         pbits = last_panel;
      end else begin
         r2 = $urandom_range(0, 99);
         n = (r2 < 80) ? $urandom_range(0, 40) :
             (r2 < 95) ? $urandom_range(41, 100) : $urandom_range(101, 140);
         for (j = 0; j < n; j++) pbits.push_back(1'($urandom_range(0, 1)));
         if (n >= 8 && $urandom_range(0, 7) == 0)
            for (j = 0; j < 8; j++) pbits[j] = 1'b0;
      end
      last_panel = pbits;

      r = $urandom_range(0, 99);
      n = (r < 15) ? $urandom_range(32, 40) :
          (r < 20) ? 0 :
          (r < 25) ? $urandom_range(100, 140) : $urandom_range(1, 40);
      for (j = 0; j < n; j++) kbits.push_back((r < 15) ? 1'b1 : 1'($urandom_range(0, 1)));
      if (r >= 25 && n >= 8 && $urandom_range(0, 5) == 0)
         for (j = 0; j < 8; j++) kbits[j] = 1'b0;
      send_frame(pbits, kbits, long_gap());
   endtask

   task automatic run_random(input int target);
      while (edges_sent < target) begin
         calm = ($urandom_range(0, 7) == 0);
         random_frame();
      end
      calm = 1'b0;
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CFG_KEYPAD_GAP;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.clock_level = 1'b0;
      req_bus.data_bit    = 1'b0;
      req_bus.gap_us      = '0;
      calm                = 1'b0;
      hold_request        = 1'b0;
      edges_sent          = 0;
      settings_used       = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_config(KEYPAD_GAP_RESET, PANEL_GAP_RESET, MIN_BITS_RESET);
      run_directed();
      drain();
      run_random(edges_sent + 200);
      drain();

      // Every edge completes a word; the sink holds off so the receiver backs up.
      set_config(16'h0000, 16'h0000, 8'd0);
      hold_request = 1'b1;
      calm = 1'b1;
      repeat (24) send_noise();
      calm = 1'b0;
      drain();

      set_config(16'd3000, 16'd3000, 8'd17);
      run_random(edges_sent + 150);
      drain();

      set_config(16'hFFFF, 16'hFFFF, 8'd128);
      repeat (20) send_noise();
      drain();

      set_config(16'd20000, 16'd200, 8'd1);
      run_random(edges_sent + 120);
      drain();

      $display("Sent %0d keybus edges under %0d register settings.", edges_sent, settings_used);
      $display("Checked %0d frame bytes from %0d completed panel words.",
               frames.bytes_checked, frames.words_completed);
      if (frames.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
